// ----- rtl/core/cdmgt_pkg.sv -----
package cdmgt_pkg;

    // conversion selector
    typedef enum logic [1:0] {
        KIND_CIV2MJD = 2'd0,
        KIND_MJD2CIV = 2'd1,
        KIND_MJD2GPS = 2'd2,
        KIND_GPS2MJD = 2'd3
    } t_kind;

    localparam int NSTG = 8;

    // time constants
    localparam logic [16:0] SEC_PER_DAY   = 17'd86400;
    localparam logic [16:0] SEC_DAY_LAST  = 17'd86399;
    localparam logic [19:0] SEC_PER_WEEK  = 20'd604800;
    localparam logic [11:0] SEC_PER_HOUR  = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN   = 6'd60;
    localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;
    localparam logic [16:0] MJD_MAX       = 17'd131071;
    localparam logic [16:0] GPS_EPOCH_MJD = 17'd44244;

    // calendar constants, 365.25 = 1461/4, 30.6001 = 306001/10000
    localparam logic [10:0] DAYS_4YR      = 11'd1461;
    localparam logic [15:0] JD_CENT       = 16'd36525;
    localparam logic [18:0] Q_E           = 19'd306001;
    localparam logic [13:0] NUM_E         = 14'd10000;
    localparam logic [6:0]  JD_SCALE      = 7'd100;
    localparam logic [22:0] MJD_OFS_CIV   = 23'd679019;
    localparam logic [21:0] B_OFS         = 22'd2401538;
    // 100 * 2401538 - 12210
    localparam logic [27:0] N_OFS         = 28'd240141590;
    localparam logic [12:0] YEAR_BASE     = 13'd4715;
    localparam logic signed [21:0] Q1461_YM1 = -22'sd365;

    // reciprocals: floor(2^s / d), quotient low by at most one
    localparam logic [12:0] RCP_36525     = 13'd7349;   // s = 28
    localparam logic [5:0]  RCP_3600      = 6'd36;      // s = 17
    localparam logic [6:0]  RCP_60        = 7'd68;      // s = 12
    localparam logic [14:0] RCP_7         = 15'd18724;  // s = 17
    localparam logic [3:0]  RCP_86400     = 4'd12;      // s = 20
    localparam logic [18:0] RCP_E         = 19'd270000; // 10000 * floor(2^23 / 306001)

    // floor(30.6001 * e)
    function automatic logic [8:0] f_q306001(input logic [4:0] i_e);
        logic [8:0] v;
        unique case (i_e)
            5'd0:    v = 9'd0;
            5'd1:    v = 9'd30;
            5'd2:    v = 9'd61;
            5'd3:    v = 9'd91;
            5'd4:    v = 9'd122;
            5'd5:    v = 9'd153;
            5'd6:    v = 9'd183;
            5'd7:    v = 9'd214;
            5'd8:    v = 9'd244;
            5'd9:    v = 9'd275;
            5'd10:   v = 9'd306;
            5'd11:   v = 9'd336;
            5'd12:   v = 9'd367;
            5'd13:   v = 9'd397;
            5'd14:   v = 9'd428;
            5'd15:   v = 9'd459;
            5'd16:   v = 9'd489;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    typedef struct packed {
        t_kind       kind;
        logic [17:0] mjd;
        logic [16:0] sod;
        logic [11:0] y;
        logic        yneg;
        logic [4:0]  tidx;
        logic [4:0]  day;
        logic [16:0] secs;
        logic [16:0] wk7;
        logic [19:0] sow;
        logic [3:0]  sq0;
    } t_s1;

    typedef struct packed {
        t_kind              kind;
        logic signed [21:0] q1461;
        logic [8:0]         tab;
        logic [4:0]         day;
        logic               dc;
        logic [16:0]        secs;
        logic [17:0]        wk;
        logic [3:0]         sq;
        logic [16:0]        srem;
        logic [27:0]        n;
        logic [21:0]        b;
        logic [4:0]         h0;
        logic [16:0]        sod;
        logic               ge;
        logic [16:0]        diff;
    } t_s2;

    typedef struct packed {
        t_kind              kind;
        logic signed [22:0] days0;
        logic [16:0]        secs;
        logic [17:0]        days3;
        logic [16:0]        srem;
        logic [12:0]        c0;
        logic [27:0]        n;
        logic [21:0]        b;
        logic [4:0]         h;
        logic [11:0]        hrem;
        logic [16:0]        sod;
        logic               ge;
        logic [13:0]        w0;
        logic [16:0]        diff;
    } t_s3;

    typedef struct packed {
        t_kind       kind;
        logic [16:0] mjd_o;
        logic [16:0] sod_o;
        logic [12:0] c;
        logic [21:0] b;
        logic [4:0]  h;
        logic [5:0]  m0;
        logic [11:0] hrem;
        logic        ge;
        logic [13:0] w;
        logic [2:0]  r7;
        logic [16:0] sod;
    } t_s4;

    // stages 5 to 7: e holds 0, then the estimate, then the corrected value
    typedef struct packed {
        t_kind       kind;
        logic [16:0] mjd_o;
        logic [16:0] sod_o;
        logic [12:0] c;
        logic [9:0]  x;
        logic [4:0]  e;
        logic [4:0]  h;
        logic [5:0]  mn;
        logic [5:0]  sc;
        logic [13:0] gw;
        logic [19:0] gs;
    } t_tail;

    typedef struct packed {
        logic [11:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
        logic [16:0] out_mjd_days;
        logic [16:0] out_sec_of_day;
        logic [13:0] out_gps_week;
        logic [19:0] out_sec_of_week;
    } t_res;

endpackage

// ----- rtl/core/cdmgt_if.sv -----
interface cdmgt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [16:0] mjd_days;
    logic [16:0] sec_of_day;
    logic [13:0] gps_week;
    logic [19:0] sec_of_week;

    modport source (
        output valid, kind, year, month, day, hour, minute, second,
               mjd_days, sec_of_day, gps_week, sec_of_week,
        input  ready
    );
    modport sink (
        input  valid, kind, year, month, day, hour, minute, second,
               mjd_days, sec_of_day, gps_week, sec_of_week,
        output ready
    );
endinterface

interface cdmgt_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] out_year;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [5:0]  out_second;
    logic [16:0] out_mjd_days;
    logic [16:0] out_sec_of_day;
    logic [13:0] out_gps_week;
    logic [19:0] out_sec_of_week;

    modport source (
        output valid, out_year, out_month, out_day, out_hour, out_minute,
               out_second, out_mjd_days, out_sec_of_day, out_gps_week,
               out_sec_of_week,
        input  ready
    );
    modport sink (
        input  valid, out_year, out_month, out_day, out_hour, out_minute,
               out_second, out_mjd_days, out_sec_of_day, out_gps_week,
               out_sec_of_week,
        output ready
    );
endinterface

// ----- rtl/core/civil_date_mjd_gps_time_convert.sv -----
// Calendar / GPS time converter, one conversion per input beat.
// i_in (sink): kind selects civil->MJD, MJD->civil, MJD->GPS or GPS->MJD;
//   only the fields that the kind uses matter. o_res (source): one result
//   beat per input beat, in order; fields the kind does not produce are 0.
// Pipeline: 8 register stages, the last one is the output register.
// Throughput: one beat per cycle while the output side takes results.
//   The depth is set by the MJD->civil path: two divisions by constants
//   (reciprocal multiply, then one compare-subtract correction), each
//   split over two stages, with the 365.25 multiply between.
// Stall: every stage holds its beat while the stage after it is full and
//   stalled; empty stages keep filling, so i_in.ready drops only once all
//   stages ahead hold data. Nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous): all stage valid bits clear; the data
//   registers are not reset. No clearing pass; first beat may come the
//   cycle after reset is released.
// MJD results clamp to 0..131071 (time 0 or 86399 at the ends); GPS
//   results before the epoch day read week 0, second 0.
module civil_date_mjd_gps_time_convert (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cdmgt_in_if.sink        i_in,
    cdmgt_out_if.source     o_res
);

    localparam int NSTG = cdmgt_pkg::NSTG;

    // ---------------- stage control ----------------
    logic [NSTG:1] r_vld;
    logic [NSTG:1] w_en;

    // a stage loads when empty or when its contents move on
    always_comb begin
        w_en[NSTG] = !r_vld[NSTG] || o_res.ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_en[k] = !r_vld[k] || w_en[k + 1];
        end
    end

    assign i_in.ready = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[1]) begin
                r_vld[1] <= i_in.valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k - 1];
                end
            end
        end
    end

    // ---------------- stage registers ----------------
    cdmgt_pkg::t_s1   r_s1, n_s1;
    cdmgt_pkg::t_s2   r_s2, n_s2;
    cdmgt_pkg::t_s3   r_s3, n_s3;
    cdmgt_pkg::t_s4   r_s4, n_s4;
    cdmgt_pkg::t_tail r_s5, n_s5;
    cdmgt_pkg::t_tail r_s6, n_s6;
    cdmgt_pkg::t_tail r_s7, n_s7;
    cdmgt_pkg::t_res  r_s8, n_s8;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) r_s1 <= n_s1;
        if (w_en[2]) r_s2 <= n_s2;
        if (w_en[3]) r_s3 <= n_s3;
        if (w_en[4]) r_s4 <= n_s4;
        if (w_en[5]) r_s5 <= n_s5;
        if (w_en[6]) r_s6 <= n_s6;
        if (w_en[7]) r_s7 <= n_s7;
        if (w_en[8]) r_s8 <= n_s8;
    end

    // ---------------- stage 1: input fold ----------------
    // Seconds of day >= 86400 carry one day (input is < 2 days).
    // Jan/Feb count as months 13/14 of the prior year.
    logic        w_s1_sge;
    logic        w_s1_mlo;
    logic [23:0] w_s1_sq_prod;

    assign w_s1_sge     = i_in.sec_of_day >= cdmgt_pkg::SEC_PER_DAY;
    assign w_s1_mlo     = i_in.month <= 4'd2;
    assign w_s1_sq_prod = 24'(i_in.sec_of_week) * 24'(cdmgt_pkg::RCP_86400);

    always_comb begin
        n_s1.kind = cdmgt_pkg::t_kind'(i_in.kind);
        n_s1.mjd  = 18'(i_in.mjd_days) + 18'(w_s1_sge);
        n_s1.sod  = w_s1_sge ? i_in.sec_of_day - cdmgt_pkg::SEC_PER_DAY
                             : i_in.sec_of_day;
        n_s1.y    = i_in.year - 12'(w_s1_mlo);
        n_s1.yneg = w_s1_mlo && (i_in.year == '0);
        n_s1.tidx = w_s1_mlo ? 5'(i_in.month) + 5'd13 : 5'(i_in.month) + 5'd1;
        n_s1.day  = i_in.day;
        n_s1.secs = 17'(i_in.hour) * 17'(cdmgt_pkg::SEC_PER_HOUR)
                  + 17'(i_in.minute) * 17'(cdmgt_pkg::SEC_PER_MIN)
                  + 17'(i_in.second);
        n_s1.wk7  = 17'(i_in.gps_week) * 17'(cdmgt_pkg::DAYS_PER_WEEK);
        n_s1.sow  = i_in.sec_of_week;
        // sec_of_week / 86400 estimate
        n_s1.sq0  = w_s1_sq_prod[23:20];
    end

    // ---------------- stage 2 ----------------
    logic [22:0] w_s2_qprod;
    logic        w_s2_dc;
    logic [19:0] w_s2_srem0;
    logic        w_s2_sge;
    logic [22:0] w_s2_hprod;

    assign w_s2_qprod = 23'(r_s1.y) * 23'(cdmgt_pkg::DAYS_4YR);
    assign w_s2_dc    = r_s1.secs >= cdmgt_pkg::SEC_PER_DAY;
    assign w_s2_srem0 = r_s1.sow - 20'(r_s1.sq0) * 20'(cdmgt_pkg::SEC_PER_DAY);
    assign w_s2_sge   = w_s2_srem0 >= 20'(cdmgt_pkg::SEC_PER_DAY);
    assign w_s2_hprod = 23'(r_s1.sod) * 23'(cdmgt_pkg::RCP_3600);

    always_comb begin
        n_s2.kind  = r_s1.kind;
        // year -1 truncates toward zero: -1461/4 = -365
        n_s2.q1461 = r_s1.yneg ? cdmgt_pkg::Q1461_YM1 : 22'(w_s2_qprod[22:2]);
        n_s2.tab   = cdmgt_pkg::f_q306001(r_s1.tidx);
        n_s2.day   = r_s1.day;
        n_s2.dc    = w_s2_dc;
        n_s2.secs  = w_s2_dc ? r_s1.secs - cdmgt_pkg::SEC_PER_DAY : r_s1.secs;
        n_s2.wk    = 18'(r_s1.wk7) + 18'(cdmgt_pkg::GPS_EPOCH_MJD);
        n_s2.sq    = r_s1.sq0 + 4'(w_s2_sge);
        n_s2.srem  = 17'(w_s2_sge ? w_s2_srem0 - 20'(cdmgt_pkg::SEC_PER_DAY)
                                  : w_s2_srem0);
        // 100 * (mjd + 2401538) - 12210
        n_s2.n     = 28'(r_s1.mjd) * 28'(cdmgt_pkg::JD_SCALE) + cdmgt_pkg::N_OFS;
        n_s2.b     = 22'(r_s1.mjd) + cdmgt_pkg::B_OFS;
        n_s2.h0    = w_s2_hprod[21:17];
        n_s2.sod   = r_s1.sod;
        n_s2.ge    = r_s1.mjd >= 18'(cdmgt_pkg::GPS_EPOCH_MJD);
        n_s2.diff  = 17'(r_s1.mjd - 18'(cdmgt_pkg::GPS_EPOCH_MJD));
    end

    // ---------------- stage 3 ----------------
    logic [40:0] w_s3_cprod;
    logic [16:0] w_s3_hrem0;
    logic        w_s3_hge;
    logic [31:0] w_s3_wprod;

    assign w_s3_cprod = 41'(r_s2.n) * 41'(cdmgt_pkg::RCP_36525);
    assign w_s3_hrem0 = r_s2.sod - 17'(r_s2.h0) * 17'(cdmgt_pkg::SEC_PER_HOUR);
    assign w_s3_hge   = w_s3_hrem0 >= 17'(cdmgt_pkg::SEC_PER_HOUR);
    assign w_s3_wprod = 32'(r_s2.diff) * 32'(cdmgt_pkg::RCP_7);

    always_comb begin
        n_s3.kind  = r_s2.kind;
        n_s3.days0 = 23'(r_s2.q1461) + 23'(r_s2.tab) + 23'(r_s2.day)
                   + 23'(r_s2.dc) - cdmgt_pkg::MJD_OFS_CIV;
        n_s3.secs  = r_s2.secs;
        n_s3.days3 = r_s2.wk + 18'(r_s2.sq);
        n_s3.srem  = r_s2.srem;
        n_s3.c0    = w_s3_cprod[40:28];
        n_s3.n     = r_s2.n;
        n_s3.b     = r_s2.b;
        n_s3.h     = r_s2.h0 + 5'(w_s3_hge);
        n_s3.hrem  = 12'(w_s3_hge ? w_s3_hrem0 - 17'(cdmgt_pkg::SEC_PER_HOUR)
                                  : w_s3_hrem0);
        n_s3.sod   = r_s2.sod;
        n_s3.ge    = r_s2.ge;
        n_s3.w0    = w_s3_wprod[30:17];
        n_s3.diff  = r_s2.diff;
    end

    // ---------------- stage 4: clamp day number, fix quotients ----------------
    logic [27:0] w_s4_crem;
    logic [18:0] w_s4_mprod;
    logic [16:0] w_s4_rem7;
    logic        w_s4_r7ge;

    assign w_s4_crem  = r_s3.n - 28'(r_s3.c0) * 28'(cdmgt_pkg::JD_CENT);
    assign w_s4_mprod = 19'(r_s3.hrem) * 19'(cdmgt_pkg::RCP_60);
    assign w_s4_rem7  = r_s3.diff - 17'(r_s3.w0) * 17'(cdmgt_pkg::DAYS_PER_WEEK);
    assign w_s4_r7ge  = w_s4_rem7 >= 17'(cdmgt_pkg::DAYS_PER_WEEK);

    always_comb begin
        n_s4.kind  = r_s3.kind;
        n_s4.mjd_o = '0;
        n_s4.sod_o = '0;
        unique case (r_s3.kind)
            cdmgt_pkg::KIND_CIV2MJD: begin
                if (r_s3.days0[22]) begin
                    // before MJD 0
                    n_s4.mjd_o = '0;
                    n_s4.sod_o = '0;
                end else if (|r_s3.days0[21:17]) begin
                    n_s4.mjd_o = cdmgt_pkg::MJD_MAX;
                    n_s4.sod_o = cdmgt_pkg::SEC_DAY_LAST;
                end else begin
                    n_s4.mjd_o = r_s3.days0[16:0];
                    n_s4.sod_o = r_s3.secs;
                end
            end
            cdmgt_pkg::KIND_GPS2MJD: begin
                if (r_s3.days3[17]) begin
                    n_s4.mjd_o = cdmgt_pkg::MJD_MAX;
                    n_s4.sod_o = cdmgt_pkg::SEC_DAY_LAST;
                end else begin
                    n_s4.mjd_o = r_s3.days3[16:0];
                    n_s4.sod_o = r_s3.srem;
                end
            end
            default: begin
                n_s4.mjd_o = '0;
                n_s4.sod_o = '0;
            end
        endcase
        n_s4.c    = r_s3.c0 + 13'(w_s4_crem >= 28'(cdmgt_pkg::JD_CENT));
        n_s4.b    = r_s3.b;
        n_s4.h    = r_s3.h;
        n_s4.m0   = w_s4_mprod[17:12];
        n_s4.hrem = r_s3.hrem;
        n_s4.ge   = r_s3.ge;
        n_s4.w    = r_s3.w0 + 14'(w_s4_r7ge);
        n_s4.r7   = 3'(w_s4_r7ge ? w_s4_rem7 - 17'(cdmgt_pkg::DAYS_PER_WEEK)
                                 : w_s4_rem7);
        n_s4.sod  = r_s3.sod;
    end

    // ---------------- stage 5: day within year, minutes, GPS ----------------
    logic [23:0] w_s5_dprod;
    logic [11:0] w_s5_mrem0;
    logic        w_s5_mge;

    assign w_s5_dprod = 24'(r_s4.c) * 24'(cdmgt_pkg::DAYS_4YR);
    assign w_s5_mrem0 = r_s4.hrem - 12'(r_s4.m0) * 12'(cdmgt_pkg::SEC_PER_MIN);
    assign w_s5_mge   = w_s5_mrem0 >= 12'(cdmgt_pkg::SEC_PER_MIN);

    always_comb begin
        n_s5.kind  = r_s4.kind;
        n_s5.mjd_o = r_s4.mjd_o;
        n_s5.sod_o = r_s4.sod_o;
        n_s5.c     = r_s4.c;
        // b - floor(365.25 c): always 123..488
        n_s5.x     = 10'(r_s4.b - 22'(w_s5_dprod[23:2]));
        n_s5.e     = '0;
        n_s5.h     = r_s4.h;
        n_s5.mn    = r_s4.m0 + 6'(w_s5_mge);
        n_s5.sc    = 6'(w_s5_mge ? w_s5_mrem0 - 12'(cdmgt_pkg::SEC_PER_MIN)
                                 : w_s5_mrem0);
        if (r_s4.kind == cdmgt_pkg::KIND_MJD2GPS && r_s4.ge) begin
            n_s5.gw = r_s4.w;
            n_s5.gs = 20'(r_s4.r7) * 20'(cdmgt_pkg::SEC_PER_DAY) + 20'(r_s4.sod);
        end else begin
            // before the GPS epoch, or another kind
            n_s5.gw = '0;
            n_s5.gs = '0;
        end
    end

    // ---------------- stage 6: month index estimate ----------------
    logic [28:0] w_s6_eprod;

    assign w_s6_eprod = 29'(r_s5.x) * 29'(cdmgt_pkg::RCP_E);

    always_comb begin
        n_s6   = r_s5;
        n_s6.e = w_s6_eprod[27:23];
    end

    // ---------------- stage 7: month index correction ----------------
    logic [23:0] w_s7_num;
    logic [23:0] w_s7_den;

    assign w_s7_num = 24'(r_s6.x) * 24'(cdmgt_pkg::NUM_E);
    assign w_s7_den = 24'(6'(r_s6.e) + 6'd1) * 24'(cdmgt_pkg::Q_E);

    always_comb begin
        n_s7   = r_s6;
        n_s7.e = r_s6.e + 5'(w_s7_num >= w_s7_den);
    end

    // ---------------- stage 8: civil fields, output register ----------------
    logic [3:0] w_s8_mo;

    assign w_s8_mo = (r_s7.e >= 5'd14) ? 4'(r_s7.e - 5'd13) : 4'(r_s7.e - 5'd1);

    always_comb begin
        n_s8.out_mjd_days    = r_s7.mjd_o;
        n_s8.out_sec_of_day  = r_s7.sod_o;
        n_s8.out_gps_week    = r_s7.gw;
        n_s8.out_sec_of_week = r_s7.gs;
        if (r_s7.kind == cdmgt_pkg::KIND_MJD2CIV) begin
            n_s8.out_year   = 12'(r_s7.c - cdmgt_pkg::YEAR_BASE
                                  - 13'(w_s8_mo >= 4'd3));
            n_s8.out_month  = w_s8_mo;
            n_s8.out_day    = 5'(r_s7.x - 10'(cdmgt_pkg::f_q306001(r_s7.e)));
            n_s8.out_hour   = r_s7.h;
            n_s8.out_minute = r_s7.mn;
            n_s8.out_second = r_s7.sc;
        end else begin
            n_s8.out_year   = '0;
            n_s8.out_month  = '0;
            n_s8.out_day    = '0;
            n_s8.out_hour   = '0;
            n_s8.out_minute = '0;
            n_s8.out_second = '0;
        end
    end

    assign o_res.valid           = r_vld[NSTG];
    assign o_res.out_year        = r_s8.out_year;
    assign o_res.out_month       = r_s8.out_month;
    assign o_res.out_day         = r_s8.out_day;
    assign o_res.out_hour        = r_s8.out_hour;
    assign o_res.out_minute      = r_s8.out_minute;
    assign o_res.out_second      = r_s8.out_second;
    assign o_res.out_mjd_days    = r_s8.out_mjd_days;
    assign o_res.out_sec_of_day  = r_s8.out_sec_of_day;
    assign o_res.out_gps_week    = r_s8.out_gps_week;
    assign o_res.out_sec_of_week = r_s8.out_sec_of_week;

endmodule

// ----- rtl/core/cdmgt_chk.sv -----
module cdmgt_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [11:0] i_out_year,
    input logic [3:0]  i_out_month,
    input logic [4:0]  i_out_day,
    input logic [4:0]  i_out_hour,
    input logic [5:0]  i_out_minute,
    input logic [5:0]  i_out_second,
    input logic [16:0] i_out_mjd_days,
    input logic [16:0] i_out_sec_of_day,
    input logic [13:0] i_out_gps_week,
    input logic [19:0] i_out_sec_of_week
);

    // reset empties the pipe
    a_rst_clr: assert property (@(posedge i_clk) !i_rst_n |=> !i_res_valid)
        else $error("result beat valid right after reset");

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid
            && $stable(i_out_year) && $stable(i_out_month) && $stable(i_out_day)
            && $stable(i_out_hour) && $stable(i_out_minute)
            && $stable(i_out_second) && $stable(i_out_mjd_days)
            && $stable(i_out_sec_of_day) && $stable(i_out_gps_week)
            && $stable(i_out_sec_of_week))
        else $error("stalled result beat changed");

    // a free output side never backs up the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid || i_res_ready |-> i_in_ready)
        else $error("input stalled with output side free");

    // civil result excludes day-number and GPS fields
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_out_month != 4'd0 |-> i_out_mjd_days == '0
            && i_out_sec_of_day == '0 && i_out_gps_week == '0
            && i_out_sec_of_week == '0)
        else $error("civil result beat carries other fields");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_out_sec_of_day < cdmgt_pkg::SEC_PER_DAY
            && i_out_sec_of_week < cdmgt_pkg::SEC_PER_WEEK)
        else $error("seconds field out of range");

endmodule

bind civil_date_mjd_gps_time_convert cdmgt_chk u_cdmgt_chk (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_ready        (i_in.ready),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_out_year        (o_res.out_year),
    .i_out_month       (o_res.out_month),
    .i_out_day         (o_res.out_day),
    .i_out_hour        (o_res.out_hour),
    .i_out_minute      (o_res.out_minute),
    .i_out_second      (o_res.out_second),
    .i_out_mjd_days    (o_res.out_mjd_days),
    .i_out_sec_of_day  (o_res.out_sec_of_day),
    .i_out_gps_week    (o_res.out_gps_week),
    .i_out_sec_of_week (o_res.out_sec_of_week)
);

// ----- tb/sv/tb_civil_date_mjd_gps_time_convert.sv -----
`timescale 1ns / 100ps

module tb_civil_date_mjd_gps_time_convert;

    // run shape
    localparam int          N_DIR     = 22;
    localparam int          N_RAND    = 1230;
    localparam int unsigned CYC_LIMIT = 200000;
    localparam int          TAIL_CYC  = 16;     // pipe is 8 deep; idle tail after the final drain

    // conversion constants used by the predictor
    localparam longint DAY_SEC   = 86400;
    localparam longint EPOCH_DAY = 44244;       // GPS week 0, day 0
    localparam longint LAST_DAY  = 131071;      // top of the 17-bit day number

    // one input beat, field for field as on the input channel
    typedef struct packed {
        cdmgt_pkg::t_kind kind;
        logic [11:0]      year;
        logic [3:0]       month;
        logic [4:0]       day;
        logic [4:0]       hour;
        logic [5:0]       minute;
        logic [5:0]       second;
        logic [16:0]      mjd;
        logic [16:0]      sod;
        logic [13:0]      week;
        logic [19:0]      sow;
    } t_stim;

    // directed row: beat, plus a hand-written answer where one is obvious
    typedef struct packed {
        t_stim           s;
        logic            known;
        cdmgt_pkg::t_res want;
    } t_row;

    logic i_clk;
    logic i_rst_n;

    cdmgt_in_if  in_if ();
    cdmgt_out_if res_if ();

    civil_date_mjd_gps_time_convert dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_res   (res_if)
    );

    // expected conversions, oldest first
    cdmgt_pkg::t_res exp_conv_q[$];
    int              conv_err_cnt = 0;
    int              res_beat_cnt = 0;
    int unsigned     cyc_cnt = 0;
    int              burst_left = 0;
    int              rdy_run = 0;
    int              rdy_mode = 0;

    // Directed beats. Order inside a row:
    //   kind, year, month, day, hour, minute, second, mjd, sod, week, sow
    // Answers are typed only for the GPS epoch, the clamps and the
    // pre-epoch zeros; the rest go through the predictor.
    t_row dir_tbl [N_DIR] = '{
        // GPS epoch, 1980-01-06 00:00:00, all four directions
        '{'{cdmgt_pkg::KIND_CIV2MJD, 1980, 1, 6, 0, 0, 0, 0, 0, 0, 0}, 1'b1,
          '{0, 0, 0, 0, 0, 0, 44244, 0, 0, 0}},
        '{'{cdmgt_pkg::KIND_MJD2CIV, 0, 0, 0, 0, 0, 0, 44244, 0, 0, 0}, 1'b1,
          '{1980, 1, 6, 0, 0, 0, 0, 0, 0, 0}},
        '{'{cdmgt_pkg::KIND_MJD2GPS, 0, 0, 0, 0, 0, 0, 44244, 0, 0, 0}, 1'b1, '0},
        '{'{cdmgt_pkg::KIND_GPS2MJD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1,
          '{0, 0, 0, 0, 0, 0, 44244, 0, 0, 0}},
        // last second before the epoch, and day 0: both read week 0
        '{'{cdmgt_pkg::KIND_MJD2GPS, 0, 0, 0, 0, 0, 0, 44243, 86399, 0, 0}, 1'b1,
          '0},
        '{'{cdmgt_pkg::KIND_MJD2GPS, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '0},
        // civil fields all zero: negative day number clamps low
        '{'{cdmgt_pkg::KIND_CIV2MJD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '0},
        // all civil fields at full scale, then GPS at full scale: clamp high
        '{'{cdmgt_pkg::KIND_CIV2MJD, 4095, 15, 31, 31, 63, 63, 0, 0, 0, 0}, 1'b1,
          '{0, 0, 0, 0, 0, 0, 131071, 86399, 0, 0}},
        '{'{cdmgt_pkg::KIND_GPS2MJD, 0, 0, 0, 0, 0, 0, 0, 0, 16383, 1048575}, 1'b1,
          '{0, 0, 0, 0, 0, 0, 131071, 86399, 0, 0}},
        // ends of the civil range
        '{'{cdmgt_pkg::KIND_CIV2MJD, 2099, 12, 31, 23, 59, 59, 0, 0, 0, 0}, 1'b0,
          '0},
        '{'{cdmgt_pkg::KIND_CIV2MJD, 1901, 1, 1, 0, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
        // hour 24 carries a day; leap day
        '{'{cdmgt_pkg::KIND_CIV2MJD, 2000, 2, 29, 24, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
        // month and day zero fold back into the prior year
        '{'{cdmgt_pkg::KIND_CIV2MJD, 2020, 0, 0, 12, 30, 30, 0, 0, 0, 0}, 1'b0,
          '0},
        // day number to civil: top, carry from sod, range ends, day 0
        '{'{cdmgt_pkg::KIND_MJD2CIV, 0, 0, 0, 0, 0, 0, 131071, 131071, 0, 0},
          1'b0, '0},
        '{'{cdmgt_pkg::KIND_MJD2CIV, 0, 0, 0, 0, 0, 0, 15385, 86399, 0, 0}, 1'b0,
          '0},
        '{'{cdmgt_pkg::KIND_MJD2CIV, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0, '0},
        '{'{cdmgt_pkg::KIND_MJD2CIV, 0, 0, 0, 0, 0, 0, 88068, 86400, 0, 0}, 1'b0,
          '0},
        '{'{cdmgt_pkg::KIND_MJD2CIV, 0, 0, 0, 0, 0, 0, 51603, 45296, 0, 0}, 1'b0,
          '0},
        // to GPS: top of range, and a sod carry that crosses the epoch
        '{'{cdmgt_pkg::KIND_MJD2GPS, 0, 0, 0, 0, 0, 0, 131071, 131071, 0, 0},
          1'b0, '0},
        '{'{cdmgt_pkg::KIND_MJD2GPS, 0, 0, 0, 0, 0, 0, 44243, 86401, 0, 0}, 1'b0,
          '0},
        // from GPS: last second of week 0, whole day in sow
        '{'{cdmgt_pkg::KIND_GPS2MJD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 604799}, 1'b0, '0},
        '{'{cdmgt_pkg::KIND_GPS2MJD, 0, 0, 0, 0, 0, 0, 0, 0, 12345, 86400}, 1'b0,
          '0}
    };

    // day number out of 17 bits: below 0 reads 0/0, above the top 131071/86399
    function automatic void clamp_day(input longint days, input longint secs,
                                      output logic [16:0] d_o,
                                      output logic [16:0] s_o);
        if (days < 0) begin
            d_o = '0;
            s_o = '0;
        end else if (days > LAST_DAY) begin
            d_o = 17'(LAST_DAY);
            s_o = 17'(DAY_SEC - 1);
        end else begin
            d_o = 17'(days);
            s_o = 17'(secs);
        end
    endfunction

    // Expected result of one beat. Exact integer forms of the float factors:
    // 365.25 -> *1461/4, 30.6001 -> *306001/10000, all divisions truncate.
    function automatic cdmgt_pkg::t_res calc_time_conv(input t_stim s);
        cdmgt_pkg::t_res r;
        longint          mjd, sod, y, m, secs, days;
        longint          b, c, d, e, dd, mo, yr, diff;
        r   = '0;
        // sod past midnight rolls into the day number (kinds 1 and 2)
        mjd = longint'(s.mjd) + longint'(s.sod) / DAY_SEC;
        sod = longint'(s.sod) % DAY_SEC;
        case (s.kind)
            cdmgt_pkg::KIND_CIV2MJD: begin
                y = longint'(s.year);
                m = longint'(s.month);
                // Jan/Feb (and month 0) count as months 13/14 of prior year
                if (m <= 2) begin
                    y = y - 1;
                    m = m + 12;
                end
                secs = longint'(s.hour) * 3600 + longint'(s.minute) * 60
                     + longint'(s.second);
                days = (y * 1461) / 4 + ((m + 1) * 306001) / 10000
                     + longint'(s.day) - 679019 + secs / DAY_SEC;
                clamp_day(days, secs % DAY_SEC, r.out_mjd_days, r.out_sec_of_day);
            end
            cdmgt_pkg::KIND_MJD2CIV: begin
                b  = mjd + 2401538;
                c  = (100 * b - 12210) / 36525;
                d  = (c * 1461) / 4;
                e  = (10000 * (b - d)) / 306001;
                dd = b - d - (e * 306001) / 10000;
                mo = e - 1 - 12 * (e / 14);
                yr = c - 4715 - (7 + mo) / 10;
                r.out_year   = 12'(yr);
                r.out_month  = 4'(mo);
                r.out_day    = 5'(dd);
                r.out_hour   = 5'(sod / 3600);
                r.out_minute = 6'((sod % 3600) / 60);
                r.out_second = 6'(sod % 60);
            end
            cdmgt_pkg::KIND_MJD2GPS: begin
                // before the epoch the result stays all zero
                if (mjd >= EPOCH_DAY) begin
                    diff = mjd - EPOCH_DAY;
                    r.out_gps_week    = 14'(diff / 7);
                    r.out_sec_of_week = 20'((diff % 7) * DAY_SEC + sod);
                end
            end
            default: begin
                days = EPOCH_DAY + longint'(s.week) * 7 + longint'(s.sow) / DAY_SEC;
                clamp_day(days, longint'(s.sow) % DAY_SEC,
                          r.out_mjd_days, r.out_sec_of_day);
            end
        endcase
        return r;
    endfunction

    task automatic flag_conv_err(input string msg);
        conv_err_cnt++;
        if (conv_err_cnt <= 10)
            $display("[%0t] result beat %0d: %s", $realtime, res_beat_cnt, msg);
    endtask

    // Present one beat, hold it until taken, then log what it should give.
    // Bursts of back-to-back beats, with idle gaps in between.
    task automatic drive_conv(input t_stim s, input bit known,
                              input cdmgt_pkg::t_res want);
        int gap;
        in_if.valid       <= 1'b1;
        in_if.kind        <= s.kind;
        in_if.year        <= s.year;
        in_if.month       <= s.month;
        in_if.day         <= s.day;
        in_if.hour        <= s.hour;
        in_if.minute      <= s.minute;
        in_if.second      <= s.second;
        in_if.mjd_days    <= s.mjd;
        in_if.sec_of_day  <= s.sod;
        in_if.gps_week    <= s.week;
        in_if.sec_of_week <= s.sow;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        exp_conv_q.push_back(known ? want : calc_time_conv(s));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            // now and then a long run with no gaps at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
            gap = $urandom_range(1, 12);
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // hold the input idle until the pipe has handed back every result
    task automatic drain_conv();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (exp_conv_q.size() != 0);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cyc_cnt <= cyc_cnt + 1;

    // Result side: check each taken beat, then pick next ready.
    // Stall modes, each held for a random run of cycles:
    //   0 always ready, 1 ready 3/4, 2 ready 1/4, 3 ready 1/4 in a fixed on/off pattern.
    always @(posedge i_clk) begin
        cdmgt_pkg::t_res got;
        cdmgt_pkg::t_res want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rdy_run      <= 0;
        end else begin
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                got = {res_if.out_year, res_if.out_month, res_if.out_day,
                       res_if.out_hour, res_if.out_minute, res_if.out_second,
                       res_if.out_mjd_days, res_if.out_sec_of_day,
                       res_if.out_gps_week, res_if.out_sec_of_week};
                if (exp_conv_q.size() == 0) begin
                    flag_conv_err($sformatf("unexpected result %h", got));
                end else begin
                    want = exp_conv_q.pop_front();
                    if (got.out_year !== want.out_year)
                        flag_conv_err($sformatf("out_year exp %0d got %0d",
                                                want.out_year, got.out_year));
                    if (got.out_month !== want.out_month)
                        flag_conv_err($sformatf("out_month exp %0d got %0d",
                                                want.out_month, got.out_month));
                    if (got.out_day !== want.out_day)
                        flag_conv_err($sformatf("out_day exp %0d got %0d",
                                                want.out_day, got.out_day));
                    if (got.out_hour !== want.out_hour)
                        flag_conv_err($sformatf("out_hour exp %0d got %0d",
                                                want.out_hour, got.out_hour));
                    if (got.out_minute !== want.out_minute)
                        flag_conv_err($sformatf("out_minute exp %0d got %0d",
                                                want.out_minute, got.out_minute));
                    if (got.out_second !== want.out_second)
                        flag_conv_err($sformatf("out_second exp %0d got %0d",
                                                want.out_second, got.out_second));
                    if (got.out_mjd_days !== want.out_mjd_days)
                        flag_conv_err($sformatf("out_mjd_days exp %0d got %0d",
                                                want.out_mjd_days, got.out_mjd_days));
                    if (got.out_sec_of_day !== want.out_sec_of_day)
                        flag_conv_err($sformatf("out_sec_of_day exp %0d got %0d",
                                                want.out_sec_of_day,
                                                got.out_sec_of_day));
                    if (got.out_gps_week !== want.out_gps_week)
                        flag_conv_err($sformatf("out_gps_week exp %0d got %0d",
                                                want.out_gps_week, got.out_gps_week));
                    if (got.out_sec_of_week !== want.out_sec_of_week)
                        flag_conv_err($sformatf("out_sec_of_week exp %0d got %0d",
                                                want.out_sec_of_week,
                                                got.out_sec_of_week));
                end
                res_beat_cnt <= res_beat_cnt + 1;
            end

            if (rdy_run == 0) begin
                rdy_mode <= $urandom_range(0, 3);
                rdy_run  <= $urandom_range(20, 150);
            end else begin
                rdy_run <= rdy_run - 1;
            end
            case (rdy_mode)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= ($urandom_range(0, 3) != 0);
                2:       res_if.ready <= ($urandom_range(0, 3) == 0);
                default: res_if.ready <= ((rdy_run % 12) < 3);
            endcase
        end
    end

    initial begin
        wait (cyc_cnt >= CYC_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_stim it;
        i_rst_n            <= 1'b0;
        in_if.valid        <= 1'b0;
        in_if.kind         <= '0;
        in_if.year         <= '0;
        in_if.month        <= '0;
        in_if.day          <= '0;
        in_if.hour         <= '0;
        in_if.minute       <= '0;
        in_if.second       <= '0;
        in_if.mjd_days     <= '0;
        in_if.sec_of_day   <= '0;
        in_if.gps_week     <= '0;
        in_if.sec_of_week  <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++)
            drive_conv(dir_tbl[i].s, dir_tbl[i].known, dir_tbl[i].want);
        drain_conv();

        // Random beats: every field starts full-width random, so the unused
        // ones toggle too; most then get an in-range time for their kind.
        for (int n = 0; n < N_RAND; n++) begin
            it.kind   = cdmgt_pkg::t_kind'($urandom_range(0, 3));
            it.year   = 12'($urandom);
            it.month  = 4'($urandom);
            it.day    = 5'($urandom);
            it.hour   = 5'($urandom);
            it.minute = 6'($urandom);
            it.second = 6'($urandom);
            it.mjd    = 17'($urandom);
            it.sod    = 17'($urandom);
            it.week   = 14'($urandom);
            it.sow    = 20'($urandom);
            if ($urandom_range(0, 99) < 85) begin
                case (it.kind)
                    cdmgt_pkg::KIND_CIV2MJD: begin
                        it.year   = 12'($urandom_range(1901, 2099));
                        it.month  = 4'($urandom_range(1, 12));
                        it.day    = 5'($urandom_range(1, 31));
                        it.hour   = 5'($urandom_range(0, 23));
                        it.minute = 6'($urandom_range(0, 59));
                        it.second = 6'($urandom_range(0, 59));
                    end
                    cdmgt_pkg::KIND_MJD2CIV: begin
                        // 1901-01-01 .. 2099-12-31
                        it.mjd = 17'($urandom_range(15385, 88068));
                        it.sod = 17'($urandom_range(0, 86399));
                    end
                    cdmgt_pkg::KIND_MJD2GPS: begin
                        it.mjd = 17'($urandom_range(44244, 131071));
                        it.sod = 17'($urandom_range(0, 86399));
                    end
                    default: begin
                        it.week = 14'($urandom_range(0, 12000));
                        it.sow  = 20'($urandom_range(0, 604799));
                    end
                endcase
            end
            drive_conv(it, 1'b0, '0);
            if (n == N_RAND / 2)
                drain_conv();
        end

        drain_conv();
        repeat (TAIL_CYC) @(posedge i_clk);
        if (conv_err_cnt == 0 && exp_conv_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
